@@ sv/cau_pkg.sv @@
`default_nettype none
package cau_pkg;
    // operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    // control that travels with each transaction down the pipeline
    typedef struct packed {
        logic vld;  // stage holds a transaction
        logic dv;   // divide: take the quotient
        logic dz;   // divide by zero
    } t_ctl;
endpackage
`default_nettype wire

@@ sv/cau_front.sv @@
`default_nettype none
module cau_front #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_vld,
    input  wire  [1:0]                   i_op,
    input  wire  signed [DATA_WIDTH-1:0] i_a_re,
    input  wire  signed [DATA_WIDTH-1:0] i_a_im,
    input  wire  signed [DATA_WIDTH-1:0] i_b_re,
    input  wire  signed [DATA_WIDTH-1:0] i_b_im,
    output cau_pkg::t_ctl                o_ctl,
    output logic [2*DATA_WIDTH-1:0]      o_den,
    output logic                         o_re_neg,
    output logic [2*DATA_WIDTH-1:0]      o_re_mag,
    output logic                         o_im_neg,
    output logic [2*DATA_WIDTH-1:0]      o_im_mag
);
    import cau_pkg::*;

    localparam int P = 2 * DATA_WIDTH;

    logic signed [P-1:0]          r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_br2, r_p_bi2;
    logic signed [DATA_WIDTH:0]   r_sr, r_si;
    logic [1:0]                   r_op;
    logic                         r_vld;

    // stage 1: products and part-wise sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_op    <= i_op;
            r_p_rr  <= i_a_re * i_b_re;
            r_p_ii  <= i_a_im * i_b_im;
            r_p_ri  <= i_a_re * i_b_im;
            r_p_ir  <= i_a_im * i_b_re;
            r_p_br2 <= i_b_re * i_b_re;
            r_p_bi2 <= i_b_im * i_b_im;
            if (i_op == OP_SUB) begin
                r_sr <= (DATA_WIDTH+1)'(i_a_re) - (DATA_WIDTH+1)'(i_b_re);
                r_si <= (DATA_WIDTH+1)'(i_a_im) - (DATA_WIDTH+1)'(i_b_im);
            end else begin
                r_sr <= (DATA_WIDTH+1)'(i_a_re) + (DATA_WIDTH+1)'(i_b_re);
                r_si <= (DATA_WIDTH+1)'(i_a_im) + (DATA_WIDTH+1)'(i_b_im);
            end
        end
    end

    // stage 2: combine products, split into sign and magnitude
    logic signed [P:0] e_rr, e_ii, e_ri, e_ir, s_re, s_im, a_re_abs, a_im_abs;
    logic [P-1:0]      n_den;

    always_comb begin
        e_rr = (P+1)'(r_p_rr);
        e_ii = (P+1)'(r_p_ii);
        e_ri = (P+1)'(r_p_ri);
        e_ir = (P+1)'(r_p_ir);
        case (r_op)
            OP_MUL: begin
                s_re = e_rr - e_ii;
                s_im = e_ri + e_ir;
            end
            OP_DIV: begin
                s_re = e_rr + e_ii;
                s_im = e_ir - e_ri;
            end
            default: begin
                s_re = (P+1)'(r_sr);
                s_im = (P+1)'(r_si);
            end
        endcase
        a_re_abs = s_re[P] ? -s_re : s_re;
        a_im_abs = s_im[P] ? -s_im : s_im;
        n_den = $unsigned(r_p_br2) + $unsigned(r_p_bi2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.vld <= 1'b0;
        end else if (i_en) begin
            o_ctl.vld <= r_vld;
        end
        if (i_en) begin
            o_ctl.dv <= (r_op == OP_DIV);
            o_ctl.dz <= (r_op == OP_DIV) && (n_den == '0);
            o_den    <= n_den;
            o_re_neg <= s_re[P];
            o_im_neg <= s_im[P];
            if (r_op == OP_MUL) begin
                o_re_mag <= a_re_abs[P-1:0] >> FRAC_BITS;
                o_im_mag <= a_im_abs[P-1:0] >> FRAC_BITS;
            end else begin
                o_re_mag <= a_re_abs[P-1:0];
                o_im_mag <= a_im_abs[P-1:0];
            end
        end
    end
endmodule
`default_nettype wire

@@ sv/cau_div_cell.sv @@
`default_nettype none
module cau_div_cell #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_en,
    input  cau_pkg::t_ctl                          i_ctl,
    input  wire  [2*DATA_WIDTH-1:0]                i_den,
    input  wire                                    i_neg,
    input  wire  [2*DATA_WIDTH-1:0]                i_mag,
    input  wire  [2*DATA_WIDTH+FRAC_BITS-1:0]      i_num,
    input  wire  [2*DATA_WIDTH-1:0]                i_rem,
    input  wire  [DATA_WIDTH-1:0]                  i_q,
    input  wire                                    i_ovf,
    output cau_pkg::t_ctl                          o_ctl,
    output logic [2*DATA_WIDTH-1:0]                o_den,
    output logic                                   o_neg,
    output logic [2*DATA_WIDTH-1:0]                o_mag,
    output logic [2*DATA_WIDTH+FRAC_BITS-1:0]      o_num,
    output logic [2*DATA_WIDTH-1:0]                o_rem,
    output logic [DATA_WIDTH-1:0]                  o_q,
    output logic                                   o_ovf
);
    import cau_pkg::*;

    localparam int P  = 2 * DATA_WIDTH;
    localparam int NW = P + FRAC_BITS;
    localparam logic [DATA_WIDTH:0] QMAX = (DATA_WIDTH+1)'(1) << (DATA_WIDTH - 1);

    logic [P-1:0]        r2;
    logic                ge;
    logic [DATA_WIDTH:0] qn;

    // one restoring step: bring down the next dividend bit, try the subtract
    always_comb begin
        r2 = {i_rem[P-2:0], i_num[NW-1]};
        ge = (r2 >= i_den);
        qn = {i_q, ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.vld <= 1'b0;
        end else if (i_en) begin
            o_ctl.vld <= i_ctl.vld;
        end
        if (i_en) begin
            o_ctl.dv <= i_ctl.dv;
            o_ctl.dz <= i_ctl.dz;
            o_den    <= i_den;
            o_neg    <= i_neg;
            o_mag    <= i_mag;
            o_num    <= i_num << 1;
            o_rem    <= ge ? r2 - i_den : r2;
            o_q      <= qn[DATA_WIDTH-1:0];
            o_ovf    <= i_ovf || (qn > QMAX);
        end
    end
endmodule
`default_nettype wire

@@ sv/complex_arith_unit_core.sv @@
// Complex arithmetic unit, signed fixed point (Q8.8 at the default widths).
// Slave channel s_axis: one transaction carries op and the operands a, b.
// op: 0 add, 1 subtract, 2 multiply, 3 divide (conjugate method).
// Master channel m_axis: one transaction per input with res_re, res_im and
// status (0 ok, 1 saturated, 2 divide by zero; a zero divisor returns 0).
// Multiply and divide truncate toward zero; out-of-range parts saturate.
// Pipeline: two front stages for products and sums, one cell per quotient
// bit of the restoring divider chain, and the output register. Every
// operation passes through the whole chain so results leave in order.
// Throughput: one transaction per cycle while the receiver accepts results;
// the divider chain is fully pipelined, one cell per bit.
// Reset clears every stage valid bit; the pipeline comes up empty.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and s_axis_tready drops in the same cycle; it rises with tready.
`default_nettype none
module complex_arith_unit_core #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8,
    localparam int IN_W  = ((2 + 4 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((2 + 2 * DATA_WIDTH + 7) / 8) * 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    // op, a_re, a_im, b_re, b_im from bit 0 up, zero padded
    input  wire  [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire              m_axis_tready,
    // res_re, res_im, status from bit 0 up, zero padded
    output logic [OUT_W-1:0] m_axis_tdata
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int P  = 2 * W;
    localparam int NW = P + FRAC_BITS;
    localparam int NS = P + FRAC_BITS;
    localparam logic [P-1:0] MAXPOS = (P)'((64'd1 << (W - 1)) - 64'd1);
    localparam logic [P-1:0] MAXNEG = (P)'(64'd1 << (W - 1));

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // front end: products and combined sums
    t_ctl         f_ctl;
    logic [P-1:0] f_den, f_re_mag, f_im_mag;
    logic         f_re_neg, f_im_neg;

    cau_front #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (s_axis_tvalid),
        .i_op     (s_axis_tdata[1:0]),
        .i_a_re   ($signed(s_axis_tdata[2 +: W])),
        .i_a_im   ($signed(s_axis_tdata[2 + W +: W])),
        .i_b_re   ($signed(s_axis_tdata[2 + 2*W +: W])),
        .i_b_im   ($signed(s_axis_tdata[2 + 3*W +: W])),
        .o_ctl    (f_ctl),
        .o_den    (f_den),
        .o_re_neg (f_re_neg),
        .o_re_mag (f_re_mag),
        .o_im_neg (f_im_neg),
        .o_im_mag (f_im_mag)
    );

    // divider chain taps, real and imaginary lanes
    t_ctl          c_ctl_r [NS+1];
    t_ctl          c_ctl_i [NS+1];
    logic [P-1:0]  c_den_r [NS+1];
    logic [P-1:0]  c_den_i [NS+1];
    logic          c_neg_r [NS+1];
    logic          c_neg_i [NS+1];
    logic [P-1:0]  c_mag_r [NS+1];
    logic [P-1:0]  c_mag_i [NS+1];
    logic [NW-1:0] c_num_r [NS+1];
    logic [NW-1:0] c_num_i [NS+1];
    logic [P-1:0]  c_rem_r [NS+1];
    logic [P-1:0]  c_rem_i [NS+1];
    logic [W-1:0]  c_q_r   [NS+1];
    logic [W-1:0]  c_q_i   [NS+1];
    logic          c_ovf_r [NS+1];
    logic          c_ovf_i [NS+1];

    // seed the chain: dividend is the magnitude scaled by the fraction bits
    assign c_ctl_r[0] = f_ctl;
    assign c_ctl_i[0] = f_ctl;
    assign c_den_r[0] = f_den;
    assign c_den_i[0] = f_den;
    assign c_neg_r[0] = f_re_neg;
    assign c_neg_i[0] = f_im_neg;
    assign c_mag_r[0] = f_re_mag;
    assign c_mag_i[0] = f_im_mag;
    assign c_num_r[0] = (NW)'(f_re_mag) << FRAC_BITS;
    assign c_num_i[0] = (NW)'(f_im_mag) << FRAC_BITS;
    assign c_rem_r[0] = '0;
    assign c_rem_i[0] = '0;
    assign c_q_r[0]   = '0;
    assign c_q_i[0]   = '0;
    assign c_ovf_r[0] = 1'b0;
    assign c_ovf_i[0] = 1'b0;

    for (genvar k = 0; k < NS; k++) begin : g_cell
        cau_div_cell #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_re (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_ctl(c_ctl_r[k]), .i_den(c_den_r[k]), .i_neg(c_neg_r[k]),
            .i_mag(c_mag_r[k]), .i_num(c_num_r[k]), .i_rem(c_rem_r[k]),
            .i_q(c_q_r[k]), .i_ovf(c_ovf_r[k]),
            .o_ctl(c_ctl_r[k+1]), .o_den(c_den_r[k+1]), .o_neg(c_neg_r[k+1]),
            .o_mag(c_mag_r[k+1]), .o_num(c_num_r[k+1]), .o_rem(c_rem_r[k+1]),
            .o_q(c_q_r[k+1]), .o_ovf(c_ovf_r[k+1])
        );
        cau_div_cell #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_im (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_ctl(c_ctl_i[k]), .i_den(c_den_i[k]), .i_neg(c_neg_i[k]),
            .i_mag(c_mag_i[k]), .i_num(c_num_i[k]), .i_rem(c_rem_i[k]),
            .i_q(c_q_i[k]), .i_ovf(c_ovf_i[k]),
            .o_ctl(c_ctl_i[k+1]), .o_den(c_den_i[k+1]), .o_neg(c_neg_i[k+1]),
            .o_mag(c_mag_i[k+1]), .o_num(c_num_i[k+1]), .o_rem(c_rem_i[k+1]),
            .o_q(c_q_i[k+1]), .o_ovf(c_ovf_i[k+1])
        );
    end

    // pick quotient or direct magnitude, then saturate and apply sign
    t_ctl         t_c;
    logic [P-1:0] m_re, m_im, k_re, k_im;
    logic         sat_re, sat_im;
    logic [W-1:0] v_re, v_im;
    logic [1:0]   n_status;

    always_comb begin
        t_c  = c_ctl_r[NS];
        m_re = !t_c.dv ? c_mag_r[NS] :
               (c_ovf_r[NS] ? MAXNEG + 1'b1 : (P)'(c_q_r[NS]));
        m_im = !t_c.dv ? c_mag_i[NS] :
               (c_ovf_i[NS] ? MAXNEG + 1'b1 : (P)'(c_q_i[NS]));
        sat_re = c_neg_r[NS] ? (m_re > MAXNEG) : (m_re > MAXPOS);
        sat_im = c_neg_i[NS] ? (m_im > MAXNEG) : (m_im > MAXPOS);
        k_re = sat_re ? (c_neg_r[NS] ? MAXNEG : MAXPOS) : m_re;
        k_im = sat_im ? (c_neg_i[NS] ? MAXNEG : MAXPOS) : m_im;
        v_re = c_neg_r[NS] ? -k_re[W-1:0] : k_re[W-1:0];
        v_im = c_neg_i[NS] ? -k_im[W-1:0] : k_im[W-1:0];
        if (t_c.dz) begin
            v_re     = '0;
            v_im     = '0;
            n_status = ST_DZ;
        end else if (sat_re || sat_im) begin
            n_status = ST_SAT;
        end else begin
            n_status = ST_OK;
        end
    end

    // output register
    logic [W-1:0] r_res_re, r_res_im;
    logic [1:0]   r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (en) begin
            m_axis_tvalid <= t_c.vld;
        end
        if (en) begin
            r_res_re <= v_re;
            r_res_im <= v_im;
            r_status <= n_status;
        end
    end

    assign m_axis_tdata = (OUT_W)'({r_status, r_res_im, r_res_re});

    // status code stays within the defined set
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_status != 2'd3))
        else $error("undefined status code");

    // divide by zero returns zero parts
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_status == ST_DZ) |-> (r_res_re == '0 && r_res_im == '0))
        else $error("divide by zero with nonzero result");

    // saturation status means one part sits at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_status == ST_SAT) |->
        (r_res_re == MAXPOS[W-1:0] || r_res_re == MAXNEG[W-1:0] ||
         r_res_im == MAXPOS[W-1:0] || r_res_im == MAXNEG[W-1:0]))
        else $error("saturation flagged without a limit value");

    // stalled output holds its result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed under stall");
endmodule
`default_nettype wire
